FILE: rtl/first_unique_byte_tracker_macros.svh
// Assertion macros used by the checker.
`ifndef FIRST_UNIQUE_BYTE_TRACKER_MACROS_SVH
`define FIRST_UNIQUE_BYTE_TRACKER_MACROS_SVH

// Property checked only while out of reset.
`define FUBT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("fubt assertion failed");

// Property checked on every edge, reset included.
`define FUBT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fubt assertion failed");

`endif

FILE: rtl/fubt_pkg.sv
`timescale 1ns / 1ps
package fubt_pkg;

  localparam int SYMBOL_COUNT  = 256;
  localparam int POSITION_BITS = 32;
  localparam int SYM_W         = 8;
  localparam int IDX_W         = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  // 4-ary registered pick tree over the cells
  localparam int LEVELS = ($clog2(SYMBOL_COUNT) + 1) / 2;
  localparam int LEAVES = 1 << (2 * LEVELS);
  localparam int INNER  = (LEAVES - 1) / 3;
  localparam int NODES  = INNER + LEAVES;

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  typedef struct packed {
    logic             valid;
    logic             live;
    logic             sat;
    logic [SYM_W-1:0] sym;
  } entry_t;

  typedef struct packed {
    logic             insert;
    logic             kill;
    logic             sat;
    logic [SYM_W-1:0] sym;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [SYM_W-1:0] sym;
  } pick_t;

endpackage

FILE: rtl/first_unique_byte_tracker.sv
// First unique byte tracker.
// Input channel in_valid/in_ready/in_symbol takes one stream byte per request.
// Result channel out_valid/out_ready carries, for every byte, the earliest
// symbol seen exactly once so far (out_first_unique, out_found) and the sticky
// out_position_overflow flag of the saturating stream position.
// Symbols seen for the first time are placed in a chain of cells in order of
// first sighting (after the position saturates, by descending symbol behind
// the rest); a repeat marks its cell dead. A registered 4-ary pick tree
// finds the first live cell. Each byte updates the cells, then its result
// passes the tree levels. Throughput: one byte per cycle unless stalled.
// Stall: the whole pipe holds while out_valid is high and out_ready is low;
// in_ready is low then. Nothing waits on the input side otherwise.
// Reset (rst_n low, synchronous) empties the chain, clears all seen flags,
// the position counter and the pipe valid flags; no clearing pass is needed.
`timescale 1ns / 1ps
module first_unique_byte_tracker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [fubt_pkg::SYM_W-1:0] in_symbol,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [fubt_pkg::SYM_W-1:0] out_first_unique,
  output logic                       out_found,
  output logic                       out_position_overflow
);

  localparam int L = fubt_pkg::LEVELS;

  logic                                en;
  logic                                acc;
  logic                                in_range;
  logic                                seen;
  logic [fubt_pkg::SYMBOL_COUNT-1:0]   seen_r;
  logic [fubt_pkg::SYMBOL_COUNT-1:0]   seen_nxt;
  logic [fubt_pkg::POSITION_BITS-1:0]  pos_r;
  logic [fubt_pkg::POSITION_BITS-1:0]  pos_nxt;
  logic [L:0]                          vld_r;
  logic [L:0]                          ovf_r;
  fubt_pkg::req_t                      req;
  fubt_pkg::entry_t                    cell_q    [fubt_pkg::SYMBOL_COUNT];
  logic                                cell_open [fubt_pkg::SYMBOL_COUNT];
  fubt_pkg::pick_t                     tree      [fubt_pkg::NODES];

  assign en       = !vld_r[L] || out_ready;
  assign in_ready = en;
  assign acc      = in_valid && en;

  assign in_range = ({1'b0, in_symbol} < (fubt_pkg::SYM_W + 1)'(fubt_pkg::SYMBOL_COUNT));
  assign seen     = seen_r[in_symbol[fubt_pkg::IDX_W-1:0]];

  assign req.insert = acc && in_range && !seen;
  assign req.kill   = acc && in_range && seen;
  assign req.sat    = (pos_r == fubt_pkg::POS_MAX);
  assign req.sym    = in_symbol;

  always_comb begin
    seen_nxt = seen_r;
    if (req.insert) begin
      seen_nxt[in_symbol[fubt_pkg::IDX_W-1:0]] = 1'b1;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (acc && (pos_r != fubt_pkg::POS_MAX)) begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      pos_r  <= '0;
      vld_r  <= '0;
      ovf_r  <= '0;
    end else begin
      seen_r <= seen_nxt;
      pos_r  <= pos_nxt;
      if (en) begin
        vld_r <= {vld_r[L-1:0], acc};
        ovf_r <= {ovf_r[L-1:0], (pos_nxt == fubt_pkg::POS_MAX)};
      end
    end
  end

  for (genvar j = 0; j < fubt_pkg::SYMBOL_COUNT; j++) begin : g_cell
    if (j == 0) begin : g_head
      fubt_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .prev      ('0),
        .prev_open (1'b0),
        .entry_r   (cell_q[j]),
        .open      (cell_open[j])
      );
    end else begin : g_body
      fubt_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .prev      (cell_q[j-1]),
        .prev_open (cell_open[j-1]),
        .entry_r   (cell_q[j]),
        .open      (cell_open[j])
      );
    end
  end

  for (genvar i = 0; i < fubt_pkg::LEAVES; i++) begin : g_leaf
    if (i < fubt_pkg::SYMBOL_COUNT) begin : g_used
      assign tree[fubt_pkg::INNER+i].found = cell_q[i].valid && cell_q[i].live;
      assign tree[fubt_pkg::INNER+i].sym   =
        (cell_q[i].valid && cell_q[i].live) ? cell_q[i].sym : '0;
    end else begin : g_pad
      assign tree[fubt_pkg::INNER+i] = '0;
    end
  end

  for (genvar k = 0; k < fubt_pkg::INNER; k++) begin : g_node
    fubt_node u_node (
      .clk    (clk),
      .en     (en),
      .kids   ({tree[4*k+4], tree[4*k+3], tree[4*k+2], tree[4*k+1]}),
      .pick_r (tree[k])
    );
  end

  assign out_valid             = vld_r[L];
  assign out_first_unique      = tree[0].sym;
  assign out_found             = tree[0].found;
  assign out_position_overflow = ovf_r[L];

endmodule

FILE: rtl/fubt_cell.sv
`timescale 1ns / 1ps
module fubt_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  fubt_pkg::req_t   req,
  input  fubt_pkg::entry_t prev,
  input  logic            prev_open,
  output fubt_pkg::entry_t entry_r,
  output logic            open
);

  fubt_pkg::entry_t entry_nxt;

  // open: a new request sorts at or before this slot
  assign open = !entry_r.valid ||
                (req.sat && entry_r.sat && (entry_r.sym < req.sym));

  always_comb begin
    entry_nxt = entry_r;
    if (req.insert) begin
      if (open && !prev_open) begin
        entry_nxt.valid = 1'b1;
        entry_nxt.live  = 1'b1;
        entry_nxt.sat   = req.sat;
        entry_nxt.sym   = req.sym;
      end else if (prev_open) begin
        entry_nxt = prev;
      end
    end else if (req.kill && entry_r.valid && (entry_r.sym == req.sym)) begin
      entry_nxt.live = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

endmodule

FILE: rtl/fubt_node.sv
`timescale 1ns / 1ps
module fubt_node (
  input  logic                   clk,
  input  logic                   en,
  input  fubt_pkg::pick_t [3:0]  kids,
  output fubt_pkg::pick_t        pick_r
);

  fubt_pkg::pick_t pick_nxt;

  // lowest child index is earliest in the chain
  always_comb begin
    pick_nxt = '0;
    for (int i = 3; i >= 0; i--) begin
      if (kids[i].found) begin
        pick_nxt = kids[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pick_r <= pick_nxt;
    end
  end

endmodule

FILE: rtl/fubt_checker.sv
`timescale 1ns / 1ps
`include "first_unique_byte_tracker_macros.svh"
module fubt_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [fubt_pkg::SYM_W-1:0] in_symbol,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [fubt_pkg::SYM_W-1:0] out_first_unique,
  input logic                       out_found,
  input logic                       out_position_overflow
);

  property p_out_hold;
    out_valid && !out_ready |=>
      out_valid && $stable({out_first_unique, out_found, out_position_overflow});
  endproperty

  property p_in_hold;
    in_valid && !in_ready |=> in_valid && $stable(in_symbol);
  endproperty

  `FUBT_ASSERT(a_out_hold, clk, rst_n, p_out_hold)
  `FUBT_ASSERT(a_in_hold, clk, rst_n, p_in_hold)
  `FUBT_ASSERT(a_none_zero, clk, rst_n, out_valid && !out_found |-> out_first_unique == '0)
  `FUBT_ASSERT(a_ready_free, clk, rst_n, !out_valid |-> in_ready)
  `FUBT_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind first_unique_byte_tracker fubt_checker u_fubt_checker (.*);
